@@ sv/zrs_pkg.sv @@
// Shared types, constants and the exp2 root table of the Zipf rank sampler.
package zrs_pkg;

    // Field and register widths
    localparam int SAMPLE_W  = 32;
    localparam int RANK_W    = 32;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int X_W       = 49;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ITEM_COUNT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZETA_TOTAL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANK_TWO_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ETA_COEFF      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_EXP      = 3'd4;

    // Register reset values
    localparam logic [31:0] ITEM_COUNT_RST     = 32'd2;
    localparam logic [63:0] ZETA_TOTAL_RST     = 64'h0000_0001_0000_0000;
    localparam logic [33:0] RANK_TWO_LIMIT_RST = 34'h2_0000_0000;
    localparam logic [47:0] ETA_COEFF_RST      = 48'h0001_0000_0000;
    localparam logic [47:0] ALPHA_EXP_RST      = 48'h0001_0000_0000;

    // How a request is resolved
    typedef enum logic [1:0] {
        CLS_ONE,
        CLS_TWO,
        CLS_POWER
    } zrs_class_t;

    // One request as it travels from the front end to the back end
    typedef struct packed {
        zrs_class_t     cls;
        logic [X_W-1:0] x;
    } zrs_item_t;

    typedef logic [31:0] zrs_root_tab_t [1:32];

    // Roots 2^(2^-i) in Q1.31, each the truncated integer square root of the previous one.
    function automatic zrs_root_tab_t exp2_roots();
        zrs_root_tab_t tab;
        logic [63:0]   c;
        logic [63:0]   v;
        logic [63:0]   r;
        logic [63:0]   bit_w;
        int            i;
        int            j;
        c = 64'd1 << 32;
        for (i = 1; i <= 32; i++)
        begin
            v     = c << 31;
            r     = 64'd0;
            bit_w = 64'd1 << 62;
            for (j = 0; j < 32; j++)
            begin
                if (v >= r + bit_w)
                begin
                    v = v - (r + bit_w);
                    r = (r >> 1) + bit_w;
                end
                else
                begin
                    r = r >> 1;
                end
                bit_w = bit_w >> 2;
            end
            c      = r;
            tab[i] = c[31:0];
        end
        return tab;
    endfunction

    localparam zrs_root_tab_t EXP2_ROOT = exp2_roots();

endpackage

@@ sv/zrs_if.sv @@
// Handshake channels for the uniform samples and the ranks.
interface zrs_sample_if;
    logic                         valid;
    logic                         ready;
    logic [zrs_pkg::SAMPLE_W-1:0] uniform_sample;

    modport source (output valid, output uniform_sample, input ready);
    modport sink   (input valid, input uniform_sample, output ready);
endinterface

interface zrs_rank_if;
    logic                       valid;
    logic                       ready;
    logic [zrs_pkg::RANK_W-1:0] rank;

    modport source (output valid, output rank, input ready);
    modport sink   (input valid, input rank, output ready);
endinterface

@@ sv/zipf_rank_sampler.sv @@
// Zipf rank sampler top level: configuration registers, front end, queue and back end.
// Throughput: one request per cycle while the output is not stalled.
// The back end has 32 squaring and 32 root-product stages.
// A stalled output holds the back end; the four-entry queue lets the front end run on.
// Reset clears all handshake state; the registers return to n = 2 and unit coefficients.
module zipf_rank_sampler #(
    parameter int SAMPLE_BITS = 32,
    parameter int RANK_BITS   = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    zrs_sample_if.sink                        sample,
    zrs_rank_if.source                        result,
    input  logic                              cfg_we,
    input  logic [zrs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [zrs_pkg::CFG_W-1:0]         cfg_data
);

    localparam int          NCLIP = (RANK_BITS < 32) ? RANK_BITS : 32;
    localparam logic [32:0] NMAX  = (33'd1 << NCLIP) - 33'd1;

    logic [31:0]        item_count_reg;
    logic [63:0]        zeta_total_reg;
    logic [33:0]        rank_two_limit_reg;
    logic [47:0]        eta_coeff_reg;
    logic [47:0]        alpha_exp_reg;
    logic [31:0]        n_eff;

    logic               f_valid;
    logic               f_ready;
    zrs_pkg::zrs_item_t f_item;
    logic               b_valid;
    logic               b_ready;
    zrs_pkg::zrs_item_t b_item;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_count_reg     <= zrs_pkg::ITEM_COUNT_RST;
            zeta_total_reg     <= zrs_pkg::ZETA_TOTAL_RST;
            rank_two_limit_reg <= zrs_pkg::RANK_TWO_LIMIT_RST;
            eta_coeff_reg      <= zrs_pkg::ETA_COEFF_RST;
            alpha_exp_reg      <= zrs_pkg::ALPHA_EXP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                zrs_pkg::CFG_ITEM_COUNT:     item_count_reg     <= cfg_data[31:0];
                zrs_pkg::CFG_ZETA_TOTAL:     zeta_total_reg     <= cfg_data;
                zrs_pkg::CFG_RANK_TWO_LIMIT: rank_two_limit_reg <= cfg_data[33:0];
                zrs_pkg::CFG_ETA_COEFF:      eta_coeff_reg      <= cfg_data[47:0];
                zrs_pkg::CFG_ALPHA_EXP:      alpha_exp_reg      <= cfg_data[47:0];
                default:
                begin
                end
            endcase
        end
    end

    // Rank count limited to what RANK_BITS can hold
    assign n_eff = (item_count_reg > NMAX[31:0]) ? NMAX[31:0] : item_count_reg;

    zrs_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (sample.valid),
        .in_ready       (sample.ready),
        .in_sample      (sample.uniform_sample),
        .zeta_total     (zeta_total_reg),
        .rank_two_limit (rank_two_limit_reg),
        .eta_coeff      (eta_coeff_reg),
        .push_valid     (f_valid),
        .push_ready     (f_ready),
        .push_item      (f_item)
    );

    zrs_queue #(
        .DEPTH (4)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_item   (b_item)
    );

    zrs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (b_valid),
        .in_ready   (b_ready),
        .in_item    (b_item),
        .item_count (n_eff),
        .alpha_exp  (alpha_exp_reg),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .out_rank   (result.rank)
    );

endmodule

@@ sv/zrs_front.sv @@
// Front end: takes samples, sorts them into rank one, rank two or power cases and forms x.
module zrs_front #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [31:0]         in_sample,
    input  logic [63:0]         zeta_total,
    input  logic [33:0]         rank_two_limit,
    input  logic [47:0]         eta_coeff,
    output logic                push_valid,
    input  logic                push_ready,
    output zrs_pkg::zrs_item_t  push_item
);

    localparam int          DROP      = (SAMPLE_BITS < 32) ? 32 - SAMPLE_BITS : 0;
    localparam logic [32:0] LOW_ONES  = (33'd1 << DROP) - 33'd1;
    localparam logic [31:0] KEEP_MASK = ~LOW_ONES[31:0];
    localparam logic [49:0] ONE_Q32   = 50'h0_0001_0000_0000;

    logic               eta_neg_reg;
    logic [47:0]        eta_mag_reg;

    logic               v1_reg;
    logic               v2_reg;
    logic               v3_reg;
    logic               rdy1;
    logic               rdy2;
    logic               rdy3;

    logic [31:0]        u1_reg;
    logic [63:0]        zh1_reg;
    logic [63:0]        zl1_reg;

    zrs_pkg::zrs_class_t cls2_reg;
    logic               wz2_reg;
    logic [47:0]        ph2_reg;
    logic [63:0]        pl2_reg;

    zrs_pkg::zrs_item_t item3_reg;

    logic [31:0]        u_masked;
    logic [63:0]        uz;
    logic [31:0]        w;
    zrs_pkg::zrs_class_t cls_next;
    logic [47:0]        m;
    logic [49:0]        xs;
    logic [48:0]        x_next;

    // Handshake chain through the three stages
    assign rdy3       = !v3_reg || push_ready;
    assign rdy2       = !v2_reg || rdy3;
    assign rdy1       = !v1_reg || rdy2;
    assign in_ready   = rdy1;
    assign push_valid = v3_reg;
    assign push_item  = item3_reg;

    assign u_masked = in_sample & KEEP_MASK;

    // Exact comparison of u * zeta against 1.0 and the rank-two limit
    assign uz = zh1_reg + {32'd0, zl1_reg[63:32]};
    always_comb
    begin
        if (uz[63:32] == 32'd0)
        begin
            cls_next = zrs_pkg::CLS_ONE;
        end
        else if (uz < {30'd0, rank_two_limit})
        begin
            cls_next = zrs_pkg::CLS_TWO;
        end
        else
        begin
            cls_next = zrs_pkg::CLS_POWER;
        end
    end

    // 1 - u as a 32-bit fraction; a zero sample is handled apart
    assign w = 32'd0 - u1_reg;

    // x = 1 - eta * (1 - u), clamped to one unit in the last place when not positive
    assign m  = wz2_reg ? eta_mag_reg : ph2_reg + {16'd0, pl2_reg[63:32]};
    assign xs = eta_neg_reg ? ONE_Q32 + {2'd0, m} : ONE_Q32 - {2'd0, m};
    assign x_next = (xs[49] || xs == 50'd0) ? 49'd1 : xs[48:0];

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        eta_neg_reg <= eta_coeff[47];
        eta_mag_reg <= eta_coeff[47] ? 48'd0 - eta_coeff : eta_coeff;
        if (rdy1 && in_valid)
        begin
            u1_reg  <= u_masked;
            zh1_reg <= 64'(u_masked) * 64'(zeta_total[63:32]);
            zl1_reg <= 64'(u_masked) * 64'(zeta_total[31:0]);
        end
        if (rdy2 && v1_reg)
        begin
            cls2_reg <= cls_next;
            wz2_reg  <= (u1_reg == 32'd0);
            ph2_reg  <= 48'(eta_mag_reg[47:32]) * 48'(w);
            pl2_reg  <= 64'(eta_mag_reg[31:0]) * 64'(w);
        end
        if (rdy3 && v2_reg)
        begin
            item3_reg.cls <= cls2_reg;
            item3_reg.x   <= x_next;
        end
    end

endmodule

@@ sv/zrs_queue.sv @@
// Short request queue between the front end and the back end.
module zrs_queue #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  zrs_pkg::zrs_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output zrs_pkg::zrs_item_t pop_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    zrs_pkg::zrs_item_t entry_reg [0:DEPTH-1];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ sv/zrs_back.sv @@
// Back end: log2 by squaring, scaling by alpha, exp2 by root products, and the rank.
module zrs_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  zrs_pkg::zrs_item_t in_item,
    input  logic [31:0]        item_count,
    input  logic [47:0]        alpha_exp,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        out_rank
);

    localparam int NSQ = 32;
    localparam int NEX = 32;
    // Normalise (2), squarings, multiply by alpha (5), root products, scale and shift (2)
    localparam int NST = 2 + NSQ + 5 + NEX + 2;

    logic                adv;
    logic                vld_reg [0:NST-1];
    zrs_pkg::zrs_class_t cls_reg [0:NST-1];
    logic                out_valid_reg;
    logic [31:0]         out_rank_reg;

    logic                aneg_reg;
    logic [47:0]         amag_reg;

    logic [48:0]         x0_reg;
    logic [5:0]          k0_reg;
    logic [5:0]          k_next;
    logic [31:0]         z_norm;

    logic [31:0]         sq_z_reg [0:NSQ];
    logic [31:0]         sq_f_reg [0:NSQ];
    logic [5:0]          sq_k_reg [0:NSQ];
    logic [63:0]         sq_p     [1:NSQ];

    logic [6:0]          l_int;
    logic [38:0]         l_val;
    logic [38:0]         l_neg_val;
    logic [37:0]         lmag_reg;
    logic                ysg0_reg;
    logic [63:0]         pll_reg;
    logic [21:0]         phh_reg;
    logic [31:0]         bl1_reg;
    logic [5:0]          bh1_reg;
    logic                ysg1_reg;
    logic [47:0]         phl_reg;
    logic [37:0]         plh_reg;
    logic [31:0]         pllh_reg;
    logic [21:0]         phh2_reg;
    logic                ysg2_reg;
    logic [53:0]         m_reg;
    logic                ysg3_reg;
    logic [53:0]         y_val;

    logic [31:0]         ex_e_reg [0:NEX];
    logic [31:0]         ex_f_reg [0:NEX];
    logic [23:0]         ex_i_reg [0:NEX];
    logic [63:0]         ex_p     [1:NEX];

    logic [63:0]         prod_reg;
    logic [23:0]         s_reg;
    logic [63:0]         q_reg;
    logic [63:0]         q_next;
    logic [127:0]        wide;
    logic [23:0]         ns;
    logic [31:0]         rank_raw;
    logic [31:0]         rank_next;

    // The whole pipeline moves when the output register is free or being emptied
    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = out_valid_reg;
    assign out_rank  = out_rank_reg;

    // Position of the leading one of x
    always_comb
    begin
        k_next = '0;
        for (int i = 0; i < zrs_pkg::X_W; i++)
        begin
            if (in_item.x[i])
            begin
                k_next = 6'(i);
            end
        end
    end

    // Mantissa in Q1.31
    assign z_norm = (k0_reg >= 6'd31) ? 32'(x0_reg >> (k0_reg - 6'd31))
                                      : 32'(x0_reg << (6'd31 - k0_reg));

    // One squaring per stage yields one fraction bit of log2
    always_comb
    begin
        for (int j = 1; j <= NSQ; j++)
        begin
            sq_p[j] = 64'(sq_z_reg[j-1]) * 64'(sq_z_reg[j-1]);
        end
    end

    // log2(x) as a signed Q.32 value and its negation
    assign l_int     = 7'(sq_k_reg[NSQ]) - 7'd32;
    assign l_val     = {l_int, sq_f_reg[NSQ]};
    assign l_neg_val = 39'd0 - l_val;

    assign y_val = ysg3_reg ? 54'd0 - m_reg : m_reg;

    // One optional product with a root per stage
    always_comb
    begin
        for (int i = 1; i <= NEX; i++)
        begin
            ex_p[i] = 64'(ex_e_reg[i-1]) * 64'(zrs_pkg::EXP2_ROOT[i]);
        end
    end

    // Scale by 2^(integer part): saturating left shift or truncating right shift
    always_comb
    begin
        wide = {64'd0, prod_reg} << s_reg[5:0];
        ns   = 24'd0 - s_reg;
        if (!s_reg[23])
        begin
            if (s_reg[22:6] != '0 || wide[127:64] != 64'd0)
            begin
                q_next = '1;
            end
            else
            begin
                q_next = wide[63:0];
            end
        end
        else if (ns[22:6] != '0)
        begin
            q_next = 64'd0;
        end
        else
        begin
            q_next = prod_reg >> ns[5:0];
        end
    end

    // Rank from the case, then limited to n with a floor of one
    always_comb
    begin
        unique case (cls_reg[NST-1])
            zrs_pkg::CLS_ONE:   rank_raw = 32'd1;
            zrs_pkg::CLS_TWO:   rank_raw = 32'd2;
            zrs_pkg::CLS_POWER:
            begin
                rank_raw = (q_reg >= 64'(item_count)) ? item_count : q_reg[31:0] + 32'd1;
            end
            default:            rank_raw = 32'd1;
        endcase
        rank_next = (rank_raw > item_count) ? item_count : rank_raw;
        if (rank_next == 32'd0)
        begin
            rank_next = 32'd1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < NST; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            out_valid_reg <= vld_reg[NST-1];
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        aneg_reg <= alpha_exp[47];
        amag_reg <= alpha_exp[47] ? 48'd0 - alpha_exp : alpha_exp;
        if (adv)
        begin
            cls_reg[0] <= in_item.cls;
            for (int i = 1; i < NST; i++)
            begin
                cls_reg[i] <= cls_reg[i-1];
            end

            x0_reg <= in_item.x;
            k0_reg <= k_next;

            sq_z_reg[0] <= z_norm;
            sq_f_reg[0] <= '0;
            sq_k_reg[0] <= k0_reg;
            for (int j = 1; j <= NSQ; j++)
            begin
                sq_z_reg[j] <= sq_p[j][63] ? sq_p[j][63:32] : sq_p[j][62:31];
                sq_f_reg[j] <= {sq_f_reg[j-1][30:0], sq_p[j][63]};
                sq_k_reg[j] <= sq_k_reg[j-1];
            end

            lmag_reg <= l_int[6] ? l_neg_val[37:0] : l_val[37:0];
            ysg0_reg <= l_int[6] ^ aneg_reg;

            pll_reg  <= 64'(amag_reg[31:0]) * 64'(lmag_reg[31:0]);
            phh_reg  <= 22'(amag_reg[47:32]) * 22'(lmag_reg[37:32]);
            bl1_reg  <= lmag_reg[31:0];
            bh1_reg  <= lmag_reg[37:32];
            ysg1_reg <= ysg0_reg;

            phl_reg  <= 48'(amag_reg[47:32]) * 48'(bl1_reg);
            plh_reg  <= 38'(amag_reg[31:0]) * 38'(bh1_reg);
            pllh_reg <= pll_reg[63:32];
            phh2_reg <= phh_reg;
            ysg2_reg <= ysg1_reg;

            m_reg    <= {phh2_reg, 32'd0} + 54'(phl_reg) + 54'(plh_reg) + 54'(pllh_reg);
            ysg3_reg <= ysg2_reg;

            ex_e_reg[0] <= 32'h8000_0000;
            ex_f_reg[0] <= y_val[31:0];
            ex_i_reg[0] <= {{2{y_val[53]}}, y_val[53:32]};
            for (int i = 1; i <= NEX; i++)
            begin
                ex_e_reg[i] <= ex_f_reg[i-1][NEX-i] ? ex_p[i][62:31] : ex_e_reg[i-1];
                ex_f_reg[i] <= ex_f_reg[i-1];
                ex_i_reg[i] <= ex_i_reg[i-1];
            end

            prod_reg <= 64'(item_count) * 64'(ex_e_reg[NEX]);
            s_reg    <= ex_i_reg[NEX] - 24'd31;

            q_reg <= q_next;

            out_rank_reg <= rank_next;
        end
    end

endmodule

@@ sv/zrs_checker.sv @@
// Port-level checks on the Zipf rank sampler and their binding to the top level.
module zrs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [31:0]                   out_rank,
    input logic                          cfg_we,
    input logic [zrs_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [zrs_pkg::CFG_W-1:0]     cfg_data
);

    logic [31:0] n_shadow_reg;

    // Track the rank count as written through the configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_shadow_reg <= zrs_pkg::ITEM_COUNT_RST;
        end
        else if (cfg_we && cfg_index == zrs_pkg::CFG_ITEM_COUNT)
        begin
            n_shadow_reg <= cfg_data[31:0];
        end
    end

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("rank request withdrawn while stalled");

    // A stalled result keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_rank))
        else $error("rank changed while stalled");

    // Ranks start at one
    a_rank_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_rank != 32'd0)
        else $error("rank of zero delivered");

    // Ranks never exceed the rank count, except the floor of one
    a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_rank <= n_shadow_reg || out_rank == 32'd1))
        else $error("rank above the configured count");

endmodule

bind zipf_rank_sampler zrs_checker u_zrs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_rank  (result.rank),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);

@@ test/zipf_rank_sampler_test.sv @@
// Self-checking testbench for the Zipf rank sampler: directed table, then random phases.
`timescale 1ns / 1ps

module zipf_rank_sampler_test;

    // Index that no register answers to; writes to it must change nothing.
    localparam logic [zrs_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int DIRECTED_ROWS = 27;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 170;
    localparam int DRAIN_CYCLES  = 90;

    typedef struct {
        bit                            is_cfg;
        logic [zrs_pkg::CFG_IDX_W-1:0] idx;
        logic [zrs_pkg::CFG_W-1:0]     data;
        logic [zrs_pkg::SAMPLE_W-1:0]  sample;
        bit                            typed;
        logic [zrs_pkg::RANK_W-1:0]    want;
    } plan_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [zrs_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [zrs_pkg::CFG_W-1:0]     cfg_data;

    zrs_sample_if smp ();
    zrs_rank_if   res ();

    zipf_rank_sampler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (smp),
        .result    (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the registers, as the block should hold them.
    logic [31:0] n_reg;
    logic [63:0] zeta_reg;
    logic [33:0] limit_reg;
    logic [47:0] eta_reg;
    logic [47:0] alpha_reg;

    logic [63:0]                root_q31 [1:32];
    logic [zrs_pkg::RANK_W-1:0] rank_queue [$];
    bit                         failed;
    bit                         quiet;
    bit                         big_stall_done;

    plan_row_t plan [0:DIRECTED_ROWS-1] = '{
        '{0, zrs_pkg::CFG_ITEM_COUNT, 64'd0, 32'h0000_0000, 1, 32'd1},
        '{0, zrs_pkg::CFG_ITEM_COUNT, 64'd0, 32'hffff_ffff, 1, 32'd1},
        '{0, zrs_pkg::CFG_ITEM_COUNT, 64'd0, 32'h8000_0000, 1, 32'd1},
        '{1, zrs_pkg::CFG_ITEM_COUNT, 64'd0, 32'd0, 0, 32'd0},
        '{1, zrs_pkg::CFG_ZETA_TOTAL, 64'hffff_ffff_ffff_ffff, 32'd0, 0, 32'd0},
        '{0, zrs_pkg::CFG_ITEM_COUNT, 64'd0, 32'hffff_ffff, 1, 32'd1},
        '{1, zrs_pkg::CFG_ITEM_COUNT, 64'd1, 32'd0, 0, 32'd0},
        '{0, zrs_pkg::CFG_ITEM_COUNT, 64'd0, 32'h0000_0001, 1, 32'd1},
        '{1, zrs_pkg::CFG_ITEM_COUNT, 64'd1000, 32'd0, 0, 32'd0},
        '{1, zrs_pkg::CFG_ZETA_TOTAL, 64'h4_0000_0000, 32'd0, 0, 32'd0},
        '{1, zrs_pkg::CFG_RANK_TWO_LIMIT, 64'h1_8000_0000, 32'd0, 0, 32'd0},
        '{1, CFG_UNUSED, 64'd123, 32'd0, 0, 32'd0},
        '{0, zrs_pkg::CFG_ITEM_COUNT, 64'd0, 32'h0000_0000, 1, 32'd1},
        '{0, zrs_pkg::CFG_ITEM_COUNT, 64'd0, 32'h4000_0000, 1, 32'd2},
        '{0, zrs_pkg::CFG_ITEM_COUNT, 64'd0, 32'h6000_0000, 0, 32'd0},
        '{0, zrs_pkg::CFG_ITEM_COUNT, 64'd0, 32'hffff_ffff, 0, 32'd0},
        '{1, zrs_pkg::CFG_ETA_COEFF, 64'h7fff_ffff_ffff, 32'd0, 0, 32'd0},
        '{0, zrs_pkg::CFG_ITEM_COUNT, 64'd0, 32'h6000_0000, 0, 32'd0},
        '{1, zrs_pkg::CFG_ALPHA_EXP, 64'h8000_0000_0000, 32'd0, 0, 32'd0},
        '{0, zrs_pkg::CFG_ITEM_COUNT, 64'd0, 32'h6000_0000, 1, 32'd1000},
        '{1, zrs_pkg::CFG_ALPHA_EXP, 64'h7fff_ffff_ffff, 32'd0, 0, 32'd0},
        '{0, zrs_pkg::CFG_ITEM_COUNT, 64'd0, 32'h6000_0000, 1, 32'd1},
        '{1, zrs_pkg::CFG_ITEM_COUNT, 64'hffff_ffff, 32'd0, 0, 32'd0},
        '{1, zrs_pkg::CFG_ALPHA_EXP, 64'h1_0000_0000, 32'd0, 0, 32'd0},
        '{1, zrs_pkg::CFG_ETA_COEFF, 64'h1_0000_0000, 32'd0, 0, 32'd0},
        '{0, zrs_pkg::CFG_ITEM_COUNT, 64'd0, 32'hc000_0000, 0, 32'd0},
        '{0, zrs_pkg::CFG_ITEM_COUNT, 64'd0, 32'hffff_ffff, 0, 32'd0}
    };

    // Clock; the single reset at the start is driven by the stimulus block.
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Truncated integer square root, digit by digit.
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 64'd0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Signed Q.32 product with the magnitude truncated toward zero.
    function automatic longint q32_mul(input longint a, input longint b);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] p;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p  = ({64'd0, ma} * {64'd0, mb}) >> 32;
        return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    // log2 of a positive Q16.32 value by repeated squaring of the mantissa.
    function automatic longint q32_log2(input logic [63:0] x);
        int          k;
        int          i;
        logic [63:0] z;
        logic [63:0] frac;
        k = 0;
        while (k < 63 && (x >> (k + 1)) != 0)
            k++;
        z    = (k >= 31) ? (x >> (k - 31)) : (x << (31 - k));
        frac = 64'd0;
        for (i = 0; i < 32; i++)
        begin
            z    = (z * z) >> 31;
            frac = frac << 1;
            if (z >= (64'd1 << 32))
            begin
                z       = z >> 1;
                frac[0] = 1'b1;
            end
        end
        return ((longint'(k) - 32) <<< 32) + longint'(frac);
    endfunction

    // Rank that the block should return for one sample under the shadow registers.
    function automatic logic [zrs_pkg::RANK_W-1:0] zipf_rank(
        input logic [zrs_pkg::SAMPLE_W-1:0] smpl);
        logic [63:0] u;
        logic [63:0] n;
        logic [63:0] uz;
        logic [63:0] e;
        logic [63:0] prod;
        logic [63:0] q;
        logic [63:0] rank;
        longint      x;
        longint      y;
        longint      s;
        int          i;
        u  = {32'd0, smpl};
        n  = {32'd0, n_reg};
        uz = u * {32'd0, zeta_reg[63:32]} + ((u * {32'd0, zeta_reg[31:0]}) >> 32);
        if (uz < (64'd1 << 32))
        begin
            rank = 64'd1;
        end
        else if (uz < {30'd0, limit_reg})
        begin
            rank = 64'd2;
        end
        else
        begin
            x = (longint'(1) <<< 32)
                - q32_mul(longint'($signed(eta_reg)), (longint'(1) <<< 32) - longint'(u));
            if (x <= 0)
                x = 1;
            y = q32_mul(longint'($signed(alpha_reg)), q32_log2(x));
            // Fractional part of y through the root table, integer part as a shift.
            e = 64'd1 << 31;
            for (i = 1; i <= 32; i++)
                if (y[32 - i])
                    e = (e * root_q31[i]) >> 31;
            prod = n * e;
            s    = (y >>> 32) - 31;
            if (s >= 0)
                q = (s >= 64 || prod > (64'hffff_ffff_ffff_ffff >> s)) ?
                    64'hffff_ffff_ffff_ffff : (prod << s);
            else
                q = (s <= -64) ? 64'd0 : (prod >> (-s));
            rank = (q >= n) ? n : q + 64'd1;
        end
        if (rank > n)
            rank = n;
        if (rank < 64'd1)
            rank = 64'd1;
        return rank[zrs_pkg::RANK_W-1:0];
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one request and record the rank it should produce once accepted.
    task automatic send_sample(input logic [zrs_pkg::SAMPLE_W-1:0] smpl, input bit typed,
                               input logic [zrs_pkg::RANK_W-1:0] want);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            smp.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        smp.valid          <= 1'b1;
        smp.uniform_sample <= smpl;
        @(posedge clk);
        while (!smp.ready)
            @(posedge clk);
        rank_queue.insert(rank_queue.size(), typed ? want : zipf_rank(smpl));
    endtask

    // Let every outstanding rank come back before touching the registers.
    task automatic drain();
        smp.valid <= 1'b0;
        while (rank_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write, after which the port is left quiet before the task returns.
    task automatic write_reg(input logic [zrs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [zrs_pkg::CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            zrs_pkg::CFG_ITEM_COUNT:     n_reg     = data[31:0];
            zrs_pkg::CFG_ZETA_TOTAL:     zeta_reg  = data;
            zrs_pkg::CFG_RANK_TWO_LIMIT: limit_reg = data[33:0];
            zrs_pkg::CFG_ETA_COEFF:      eta_reg   = data[47:0];
            zrs_pkg::CFG_ALPHA_EXP:      alpha_reg = data[47:0];
            default:                     ;
        endcase
        @(posedge clk);
    endtask

    // A signed Q16.32 value of modest size, or any pattern at all.
    function automatic logic [47:0] coeff_value();
        logic [47:0] v;
        v = {16'($urandom_range(0, 7)), $urandom()};
        if ($urandom_range(0, 4) == 0)
            v = 48'({$urandom(), $urandom()});
        else if ($urandom_range(0, 1) == 0)
            v = -v;
        return v;
    endfunction

    // Pick a full set of registers for one random phase; the first phase uses the extremes.
    task automatic random_setting(input int phase);
        logic [63:0] n;
        if (phase == 0)
        begin
            write_reg(zrs_pkg::CFG_ITEM_COUNT, 64'hffff_ffff);
            write_reg(zrs_pkg::CFG_ZETA_TOTAL, 64'h1_0000_0001);
            write_reg(zrs_pkg::CFG_RANK_TWO_LIMIT, 64'h3_ffff_ffff);
            write_reg(zrs_pkg::CFG_ETA_COEFF, 64'h8000_0000_0000);
            write_reg(zrs_pkg::CFG_ALPHA_EXP, 64'h7fff_ffff_ffff);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:       n = 64'd2;
                1:       n = 64'($urandom_range(3, 5000));
                2:       n = 64'($urandom());
                default: n = 64'hffff_ffff;
            endcase
            write_reg(zrs_pkg::CFG_ITEM_COUNT, n);
            if (phase == RANDOM_PHASES - 1)
                write_reg(zrs_pkg::CFG_ZETA_TOTAL, {$urandom(), $urandom()});
            else
                write_reg(zrs_pkg::CFG_ZETA_TOTAL,
                          {32'($urandom_range(1, 30)), $urandom()});
            write_reg(zrs_pkg::CFG_RANK_TWO_LIMIT, 64'({2'b01, $urandom()}));
            write_reg(zrs_pkg::CFG_ETA_COEFF, 64'(coeff_value()));
            write_reg(zrs_pkg::CFG_ALPHA_EXP, 64'(coeff_value()));
        end
    endtask

    // Stimulus: reset, directed table, then random phases.
    initial
    begin
        int i;
        int p;
        failed         = 1'b0;
        quiet          = 1'b0;
        big_stall_done = 1'b0;
        n_reg          = zrs_pkg::ITEM_COUNT_RST;
        zeta_reg       = zrs_pkg::ZETA_TOTAL_RST;
        limit_reg      = zrs_pkg::RANK_TWO_LIMIT_RST;
        eta_reg        = zrs_pkg::ETA_COEFF_RST;
        alpha_reg      = zrs_pkg::ALPHA_EXP_RST;
        root_q31[1]    = int_sqrt(64'd1 << 63);
        for (i = 2; i <= 32; i++)
            root_q31[i] = int_sqrt(root_q31[i - 1] << 31);
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= zrs_pkg::CFG_ITEM_COUNT;
        cfg_data           <= 64'd0;
        smp.valid          <= 1'b0;
        smp.uniform_sample <= 32'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (plan[i].is_cfg)
            begin
                drain();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
            begin
                send_sample(plan[i].sample, plan[i].typed, plan[i].want);
            end
        end

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            drain();
            random_setting(p);
            quiet = (p == 2);
            for (i = 0; i < PHASE_ITEMS; i++)
                send_sample($urandom(), 1'b0, '0);
        end

        drain();
        if (!failed)
            $display("zipf_rank_sampler verification clean");
        else
            $display("zipf_rank_sampler verification failed");
        $finish;
    end

    // Rank side: random back-pressure, one long hold-off, and the comparison.
    initial
    begin
        int hold;
        int seen;
        logic [zrs_pkg::RANK_W-1:0] want;
        hold = 0;
        seen = 0;
        res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res.valid && res.ready)
            begin
                seen++;
                if (rank_queue.size() == 0)
                begin
                    $display("%0t: rank %0d arrived with no request outstanding", $time, res.rank);
                    failed = 1'b1;
                end
                else
                begin
                    want = rank_queue.pop_front();
                    if (res.rank !== want)
                    begin
                        $display("%0t: rank mismatch, expected %0d, got %0d",
                                 $time, want, res.rank);
                        failed = 1'b1;
                    end
                end
            end
            // Once in the run, stop taking ranks long enough for the queue to back up.
            if (!big_stall_done && seen >= 300)
            begin
                big_stall_done = 1'b1;
                hold           = 400;
            end
            if (hold > 0)
            begin
                res.ready <= 1'b0;
                hold--;
            end
            else
            begin
                res.ready <= 1'b1;
                hold = idle_cycles();
            end
        end
    end

    // Watchdog.
    initial
    begin
        #2000000;
        $display("zipf_rank_sampler verification failed");
        $finish;
    end

endmodule
